// ===== rtl/rabin_content_defined_chunker_core_assert.svh =====
// Assertion macros for the Rabin chunker core.
// Included by the top level; no other dependencies.
`ifndef RABIN_CONTENT_DEFINED_CHUNKER_CORE_ASSERT_SVH
`define RABIN_CONTENT_DEFINED_CHUNKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset
`define RCDC_ASSERT_ALWAYS(lbl, clk_sig, rstn_sig, cond, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle
`define RCDC_ASSERT_IMPLY(lbl, clk_sig, rstn_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
    else $error(msg);

`else

`define RCDC_ASSERT_ALWAYS(lbl, clk_sig, rstn_sig, cond, msg)
`define RCDC_ASSERT_IMPLY(lbl, clk_sig, rstn_sig, ante, cons, msg)

`endif

`endif

// ===== rtl/rcdc_pkg.sv =====
// Shared types and constants for the Rabin content-defined chunker.
// No dependencies; used by rcdc_tables and the core top level.
`default_nettype none

package rcdc_pkg;

  // Chunk length width (fixed by the payload format)
  localparam int LENGTH_BITS      = 24;
  localparam int WINDOW_BYTES_DEF = 64;

  // Item opcodes
  localparam logic [1:0] OP_DATA   = 2'd0;
  localparam logic [1:0] OP_OUT_WR = 2'd1;
  localparam logic [1:0] OP_RED_WR = 2'd2;

  // Cut reasons
  localparam logic [1:0] RSN_MATCH = 2'd0;
  localparam logic [1:0] RSN_MAX   = 2'd1;
  localparam logic [1:0] RSN_EOF   = 2'd2;

  // Register map (8-byte stride)
  localparam int         CFG_ADDR_BITS = 5;
  localparam logic [1:0] REG_SHIFT     = 2'd0;
  localparam logic [1:0] REG_MIN       = 2'd1;
  localparam logic [1:0] REG_MAX       = 2'd2;
  localparam logic [1:0] REG_MASK      = 2'd3;

  // Register reset values
  localparam logic [5:0]             SHIFT_RST = 6'd45;
  localparam logic [LENGTH_BITS-1:0] MIN_RST   = 24'd524288;
  localparam logic [LENGTH_BITS-1:0] MAX_RST   = 24'd8388608;
  localparam logic [63:0]            MASK_RST  = 64'hF_FFFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  table_index;
    logic [63:0] table_value;
    logic [7:0]  data_byte;
    logic        end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] chunk_length;
    logic [1:0]             cut_reason;
    logic [63:0]            final_digest;
  } out_item_t;

  // Control from the sequencer to the table memories
  typedef struct packed {
    logic        out_we;
    logic        red_we;
    logic [7:0]  wr_idx;
    logic [63:0] wr_value;
    logic        out_re;
    logic [7:0]  out_ra;
    logic        red_re;
    logic [7:0]  red_ra;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rabin_content_defined_chunker_core.sv =====
// Rabin content-defined chunker: top level with sequencer, window memory and config port.
// Depends on rcdc_pkg, rcdc_tables and the assertion macro header.
`default_nettype none

// A data byte passes through two engine states: ST_P1 forms the reduce-table index
// from the digest and issues the reduce read, ST_P2 folds the read data into the
// digest and decides the cut. That digest loop through the reduce table sets the
// rate: a new data byte is taken only as the previous one leaves ST_P2, which a cut
// holds while the output register is full; a table write ends in ST_P1. The byte
// leaving the window and its out-table entry are prefetched during the previous
// byte, so they add no state. A result beat appears in the cycle after the byte
// leaves ST_P2 and is held in an output register while the engine keeps taking
// input; a later cut waits for it. The tables are undefined until written and
// need no clearing pass; the window is tracked by a count and is never wiped.
`include "rabin_content_defined_chunker_core_assert.svh"

module rabin_content_defined_chunker_core #(
  parameter int WINDOW_BYTES = rcdc_pkg::WINDOW_BYTES_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // item input
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire rcdc_pkg::in_item_t                   in_data,
  // result output
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output rcdc_pkg::out_item_t                       out_data,
  // configuration
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [rcdc_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  wire logic [63:0]                          cfg_pwdata,
  output logic [63:0]                               cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int LB = rcdc_pkg::LENGTH_BITS;
  localparam int PW = $clog2(WINDOW_BYTES);
  localparam int RW = $clog2(WINDOW_BYTES + 1);
  localparam logic [LB-1:0] WIN_LEN  = LB'(WINDOW_BYTES);
  localparam logic [RW-1:0] FULL_CNT = RW'(WINDOW_BYTES);
  localparam logic [PW-1:0] PTR_LAST = PW'(WINDOW_BYTES - 1);

  typedef enum logic [1:0] {ST_EMPTY, ST_P1, ST_P2} state_t;

  // ---------------- configuration registers ----------------
  logic [5:0]    shift_r;
  logic [LB-1:0] min_r;
  logic [LB-1:0] max_r;
  logic [63:0]   mask_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[rcdc_pkg::CFG_ADDR_BITS-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= rcdc_pkg::SHIFT_RST;
      min_r   <= rcdc_pkg::MIN_RST;
      max_r   <= rcdc_pkg::MAX_RST;
      mask_r  <= rcdc_pkg::MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rcdc_pkg::REG_SHIFT: shift_r <= cfg_pwdata[5:0];
        rcdc_pkg::REG_MIN:   min_r   <= cfg_pwdata[LB-1:0];
        rcdc_pkg::REG_MAX:   max_r   <= cfg_pwdata[LB-1:0];
        rcdc_pkg::REG_MASK:  mask_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      rcdc_pkg::REG_SHIFT: cfg_prdata = 64'(shift_r);
      rcdc_pkg::REG_MIN:   cfg_prdata = 64'(min_r);
      rcdc_pkg::REG_MAX:   cfg_prdata = 64'(max_r);
      rcdc_pkg::REG_MASK:  cfg_prdata = mask_r;
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- sequencer state ----------------
  state_t              state_r, state_nxt;
  rcdc_pkg::in_item_t  item_r;
  logic [63:0]         digest_r, digest_nxt;
  logic [LB-1:0]       count_r, count_nxt;
  logic [PW-1:0]       ptr_r, ptr_nxt;
  logic [RW-1:0]       rolled_r, rolled_nxt;
  logic                out_valid_r, out_valid_nxt;
  rcdc_pkg::out_item_t out_data_r;
  logic [63:0]         d_r;
  logic                rolls_r;

  // window memory
  logic [7:0]          win_mem [WINDOW_BYTES];
  logic [7:0]          win_q_r;

  // table interface
  rcdc_pkg::tbl_ctrl_t tctl;
  logic [63:0]         tbl_out_q;
  logic [63:0]         tbl_red_q;
  logic [63:0]         tbl_out0;

  logic          is_data;
  logic          in_p1, in_p2;
  logic          p1_done, p2_done, eng_free, in_accept, out_free;
  logic [LB-1:0] first_rolled;
  logic          rolls, full;
  logic [PW-1:0] ptr_inc;
  logic [63:0]   d_c, d_shift;
  logic [LB-1:0] cnt1;
  logic [63:0]   digest_new;
  logic          cut;
  logic [1:0]    reason;

  assign is_data  = (item_r.opcode == rcdc_pkg::OP_DATA);
  assign in_p1    = (state_r == ST_P1);
  assign in_p2    = (state_r == ST_P2);
  assign out_free = !out_valid_r || !out_stall;

  // ST_P1 of a byte: leaving byte, index into reduce table
  assign first_rolled = (min_r > WIN_LEN) ? (min_r - WIN_LEN) : '0;
  assign rolls        = (count_r >= first_rolled);
  assign full         = (rolled_r == FULL_CNT);
  assign ptr_inc      = (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
  assign d_c          = digest_r ^ (full ? tbl_out_q : tbl_out0);
  assign d_shift      = d_c >> shift_r;

  // ST_P2: fold reduce entry, decide the cut
  assign cnt1       = count_r + 1'b1;
  assign digest_new = rolls_r ? ({d_r[55:0], item_r.data_byte} ^ tbl_red_q) : digest_r;

  always_comb begin
    cut    = 1'b1;
    reason = rcdc_pkg::RSN_EOF;
    if (item_r.end_of_input && (cnt1 <= min_r)) begin
      reason = rcdc_pkg::RSN_EOF;
    end else if ((cnt1 >= min_r) && ((digest_new & mask_r) == '0)) begin
      reason = rcdc_pkg::RSN_MATCH;
    end else if (cnt1 >= max_r) begin
      reason = rcdc_pkg::RSN_MAX;
    end else if (item_r.end_of_input) begin
      reason = rcdc_pkg::RSN_EOF;
    end else begin
      cut = 1'b0;
    end
  end

  // handshake
  assign p1_done   = in_p1 && !is_data;
  assign p2_done   = in_p2 && (!cut || out_free);
  assign eng_free  = (state_r == ST_EMPTY) || p1_done || p2_done;
  assign in_stall  = !eng_free;
  assign in_accept = in_valid && eng_free;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    digest_nxt    = digest_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    rolled_nxt    = rolled_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_p1 && is_data && rolls) begin
      ptr_nxt    = ptr_inc;
      rolled_nxt = full ? rolled_r : rolled_r + 1'b1;
    end
    if (p2_done) begin
      if (cut) begin
        digest_nxt    = '0;
        count_nxt     = '0;
        ptr_nxt       = '0;
        rolled_nxt    = '0;
        out_valid_nxt = 1'b1;
      end else begin
        digest_nxt = digest_new;
        count_nxt  = cnt1;
      end
    end
    if (in_accept) begin
      state_nxt = ST_P1;
    end else if (in_p1 && is_data) begin
      state_nxt = ST_P2;
    end else if (p1_done || p2_done) begin
      state_nxt = ST_EMPTY;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EMPTY;
      digest_r    <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      rolled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      digest_r    <= digest_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rolled_r    <= rolled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (in_p1 && is_data) begin
      d_r     <= d_c;
      rolls_r <= rolls;
    end
    if (p2_done && cut) begin
      out_data_r.chunk_length <= cnt1;
      out_data_r.cut_reason   <= reason;
      out_data_r.final_digest <= digest_new;
    end
  end

  // window: write current byte, prefetch the next leaving byte; a byte that
  // only counts leaves the pointer and the prefetched byte alone
  always_ff @(posedge clk) begin
    if (in_p1 && is_data && rolls) begin
      win_mem[ptr_r] <= item_r.data_byte;
      win_q_r        <= win_mem[ptr_inc];
    end
  end

  // table control
  always_comb begin
    tctl.out_we   = in_p1 && (item_r.opcode == rcdc_pkg::OP_OUT_WR);
    tctl.red_we   = in_p1 && (item_r.opcode == rcdc_pkg::OP_RED_WR);
    tctl.wr_idx   = item_r.table_index;
    tctl.wr_value = item_r.table_value;
    tctl.out_re   = in_p2;
    tctl.out_ra   = win_q_r;
    tctl.red_re   = in_p1 && is_data;
    tctl.red_ra   = d_shift[7:0];
  end

  rcdc_tables u_tables (
    .clk   (clk),
    .ctrl  (tctl),
    .out_q (tbl_out_q),
    .red_q (tbl_red_q),
    .out0  (tbl_out0)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  `RCDC_ASSERT_IMPLY(a_p2_data, clk, rst_n, state_r == ST_P2, item_r.opcode == rcdc_pkg::OP_DATA, "second cycle on a non-data item")
  `RCDC_ASSERT_ALWAYS(a_rolled_cap, clk, rst_n, rolled_r <= FULL_CNT, "rolled count above window size")
  `RCDC_ASSERT_IMPLY(a_fresh_chunk, clk, rst_n, (count_r == '0) && (state_r != ST_P2), (digest_r == '0) && (rolled_r == '0) && (ptr_r == '0), "empty chunk with live digest state")

endmodule

`default_nettype wire

// ===== rtl/rcdc_tables.sv =====
// Out and reduce tables (256 x 64 each) with registered reads.
// Depends on rcdc_pkg for the control struct.
`default_nettype none

module rcdc_tables (
  input  wire logic               clk,
  input  wire rcdc_pkg::tbl_ctrl_t ctrl,
  output logic [63:0]             out_q,
  output logic [63:0]             red_q,
  output logic [63:0]             out0
);

  logic [63:0] out_mem [256];
  logic [63:0] red_mem [256];
  logic [7:0]  out_ra_r;
  logic [63:0] out_q_r;
  logic [63:0] red_q_r;
  logic [63:0] out0_r;

  // Out table: write port, prefetch read, forward a write that hits the held entry
  always_ff @(posedge clk) begin
    if (ctrl.out_we) begin
      out_mem[ctrl.wr_idx] <= ctrl.wr_value;
    end
    if (ctrl.out_re) begin
      out_q_r  <= out_mem[ctrl.out_ra];
      out_ra_r <= ctrl.out_ra;
    end else if (ctrl.out_we && (ctrl.wr_idx == out_ra_r)) begin
      out_q_r <= ctrl.wr_value;
    end
  end

  // Shadow of entry zero, used while the window is not yet full
  always_ff @(posedge clk) begin
    if (ctrl.out_we && (ctrl.wr_idx == 8'd0)) begin
      out0_r <= ctrl.wr_value;
    end
  end

  // Reduce table
  always_ff @(posedge clk) begin
    if (ctrl.red_we) begin
      red_mem[ctrl.wr_idx] <= ctrl.wr_value;
    end
    if (ctrl.red_re) begin
      red_q_r <= red_mem[ctrl.red_ra];
    end
  end

  assign out_q = out_q_r;
  assign red_q = red_q_r;
  assign out0  = out0_r;

endmodule

`default_nettype wire
